FILE: src/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants for markdown text statistics
// Beat layouts of both channels, line scanner phases, character codes and
// the constants of the reading time division.
// ----------------------------------------------------------------------------
package mts_pkg;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       byte_valid;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [31:0] character_count;
      logic [31:0] word_count;
      logic [24:0] reading_minutes;
   } rsp_type;

   typedef enum logic [2:0] {
      FenceLead,
      FenceBt1,
      FenceBt2,
      FenceTl1,
      FenceTl2,
      FenceHit,
      FenceFail
   } fence_phase_type;

   typedef enum logic [2:0] {
      MarkStart,
      MarkD1,
      MarkD2,
      MarkDashes,
      MarkP1,
      MarkP2,
      MarkDots,
      MarkFail
   } marker_phase_type;

   localparam logic [7:0] ChrTab      = 8'h09;
   localparam logic [7:0] ChrLf       = 8'h0A;
   localparam logic [7:0] ChrVtab     = 8'h0B;
   localparam logic [7:0] ChrFf       = 8'h0C;
   localparam logic [7:0] ChrCr       = 8'h0D;
   localparam logic [7:0] ChrSpace    = 8'h20;
   localparam logic [7:0] ChrDash     = 8'h2D;
   localparam logic [7:0] ChrDot      = 8'h2E;
   localparam logic [7:0] ChrDigit0   = 8'h30;
   localparam logic [7:0] ChrDigit9   = 8'h39;
   localparam logic [7:0] ChrUpperA   = 8'h41;
   localparam logic [7:0] ChrUpperZ   = 8'h5A;
   localparam logic [7:0] ChrBacktick = 8'h60;
   localparam logic [7:0] ChrLowerA   = 8'h61;
   localparam logic [7:0] ChrLowerZ   = 8'h7A;
   localparam logic [7:0] ChrTilde    = 8'h7E;
   localparam logic [7:0] ContMask    = 8'hC0;
   localparam logic [7:0] ContCode    = 8'h80;

   localparam int          MinutesBits      = 25;
   localparam logic [24:0] MinutesMax       = 25'h1FF_FFFF;
   localparam logic [33:0] WordsRoundUp     = 34'd199;
   localparam logic [33:0] MinutesWordLimit = 34'd6710886200;
   localparam int          ScaledBits       = 30;
   localparam int          RecipBits        = 31;
   localparam logic [30:0] RecipMul         = 31'd1374389535;
   localparam int          RecipShift       = 35;

endpackage

FILE: src/markdown_text_statistics.sv
// ----------------------------------------------------------------------------
// markdown_text_statistics: character, word and reading time counter
// Takes one document byte per request beat, one beat per cycle while req_stall
// is low, with no gaps needed between documents. Lines end at CR, LF or CRLF;
// fence lines, lines inside fences and a closed frontmatter block are not
// counted. A beat with end_of_text produces one response beat after it is
// accepted, passing the input register, the line scanner and the final totals,
// clamp, multiply and response registers of the reading time path; further
// documents keep streaming while a response waits, until the result pipeline is full.
// Counters are COUNT_BITS wide and saturate.
// ----------------------------------------------------------------------------
module markdown_text_statistics #(
   parameter int COUNT_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mts_pkg::rsp_type rsp_data
);
   import mts_pkg::*;

   logic                  fin_valid;
   logic                  fin_ready;
   logic [COUNT_BITS-1:0] fin_characters;
   logic [COUNT_BITS-1:0] fin_words;

   mts_scan #(
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .fin_valid      (fin_valid),
      .fin_ready      (fin_ready),
      .fin_characters (fin_characters),
      .fin_words      (fin_words)
   );

   mts_result #(
      .COUNT_BITS (COUNT_BITS)
   ) u_result (
      .clock          (clock),
      .reset          (reset),
      .fin_valid      (fin_valid),
      .fin_ready      (fin_ready),
      .fin_characters (fin_characters),
      .fin_words      (fin_words),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

   // input only backs up behind a blocked end of text beat
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> fin_valid && !fin_ready)
      else $error("request stalled without a blocked final beat");

   // a blocked final beat stays until the result pipeline takes it
   assert property (@(posedge clock) disable iff (reset)
      fin_valid && !fin_ready |=> fin_valid)
      else $error("final totals dropped while blocked");

   // reading time is zero exactly when there are no words
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.word_count == 32'd0) == (rsp_data.reading_minutes == 25'd0)))
      else $error("reading time inconsistent with word count");

endmodule

FILE: src/mts_scan.sv
// ----------------------------------------------------------------------------
// mts_scan: line scanner for markdown text statistics
// Registers each request beat, splits lines, counts code points and words,
// tracks fences and frontmatter, and hands the final totals downstream.
// ----------------------------------------------------------------------------
module mts_scan #(
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mts_pkg::req_type      req_data,
   output logic                  fin_valid,
   input  logic                  fin_ready,
   output logic [COUNT_BITS-1:0] fin_characters,
   output logic [COUNT_BITS-1:0] fin_words
);
   import mts_pkg::*;

   localparam logic [COUNT_BITS-1:0] CountMax = '1;

   logic                  beat_valid_ff, beat_valid_in;
   req_type               beat_ff, beat_in;
   logic [COUNT_BITS-1:0] total_chars_ff, total_chars_in;
   logic [COUNT_BITS-1:0] total_words_ff, total_words_in;
   logic [COUNT_BITS-1:0] line_chars_ff, line_chars_in;
   logic [COUNT_BITS-1:0] line_words_ff, line_words_in;
   logic                  in_word_ff, in_word_in;
   logic                  in_fence_ff, in_fence_in;
   logic                  prev_cr_ff, prev_cr_in;
   logic                  first_line_ff, first_line_in;
   logic                  seeking_ff, seeking_in;
   fence_phase_type       fence_ph_ff, fence_ph_in;
   marker_phase_type      marker_ph_ff, marker_ph_in;

   logic [7:0]            chr;
   logic                  skip_lf;
   logic                  line_break;
   logic                  content;
   logic                  char_inc;
   logic                  word_byte;
   logic                  word_inc;
   logic                  step;
   logic [COUNT_BITS-1:0] line_chars_next;
   logic [COUNT_BITS-1:0] line_words_next;
   fence_phase_type       fence_next;
   marker_phase_type      marker_next;
   logic                  dashes;
   logic                  dots;
   logic                  close_hit;
   logic                  fence_hit;
   logic                  add_line;
   logic [COUNT_BITS:0]   char_sum;
   logic [COUNT_BITS:0]   word_sum;
   logic [COUNT_BITS-1:0] ended_chars;
   logic [COUNT_BITS-1:0] ended_words;
   logic                  ended_fence;
   logic                  ended_seeking;

   function automatic logic is_word_byte(input logic [7:0] c);
      return (c >= ChrDigit0 && c <= ChrDigit9) || (c >= ChrUpperA && c <= ChrUpperZ) ||
             (c >= ChrLowerA && c <= ChrLowerZ) || c[7];
   endfunction

   function automatic logic is_trim_space(input logic [7:0] c);
      return c == ChrSpace || c == ChrTab || c == ChrVtab || c == ChrFf;
   endfunction

   function automatic fence_phase_type next_fence(input fence_phase_type p,
                                                  input logic [7:0] c);
      fence_phase_type n;
      n = FenceFail;
      case (p)
         FenceLead: begin
            if (c == ChrSpace || c == ChrTab) n = FenceLead;
            else if (c == ChrBacktick)        n = FenceBt1;
            else if (c == ChrTilde)           n = FenceTl1;
         end
         FenceBt1: n = (c == ChrBacktick) ? FenceBt2 : FenceFail;
         FenceBt2: n = (c == ChrBacktick) ? FenceHit : FenceFail;
         FenceTl1: n = (c == ChrTilde) ? FenceTl2 : FenceFail;
         FenceTl2: n = (c == ChrTilde) ? FenceHit : FenceFail;
         FenceHit: n = FenceHit;
         default:  n = FenceFail;
      endcase
      return n;
   endfunction

   function automatic marker_phase_type next_marker(input marker_phase_type p,
                                                    input logic [7:0] c);
      marker_phase_type n;
      n = MarkFail;
      case (p)
         MarkStart: begin
            if (c == ChrDash)     n = MarkD1;
            else if (c == ChrDot) n = MarkP1;
         end
         MarkD1:     n = (c == ChrDash) ? MarkD2 : MarkFail;
         MarkD2:     n = (c == ChrDash) ? MarkDashes : MarkFail;
         MarkDashes: n = is_trim_space(c) ? MarkDashes : MarkFail;
         MarkP1:     n = (c == ChrDot) ? MarkP2 : MarkFail;
         MarkP2:     n = (c == ChrDot) ? MarkDots : MarkFail;
         MarkDots:   n = is_trim_space(c) ? MarkDots : MarkFail;
         default:    n = MarkFail;
      endcase
      return n;
   endfunction

   // byte classification and per-line update
   always_comb begin
      chr        = beat_ff.text_byte;
      skip_lf    = beat_ff.byte_valid && prev_cr_ff && chr == ChrLf;
      line_break = beat_ff.byte_valid && !skip_lf && (chr == ChrCr || chr == ChrLf);
      content    = beat_ff.byte_valid && !skip_lf && !line_break;
      char_inc   = content && ((chr & ContMask) != ContCode);
      word_byte  = is_word_byte(chr);
      word_inc   = content && word_byte && !in_word_ff;

      line_chars_next = (line_chars_ff == CountMax) ? line_chars_ff :
                        line_chars_ff + {{(COUNT_BITS-1){1'b0}}, char_inc};
      line_words_next = (line_words_ff == CountMax) ? line_words_ff :
                        line_words_ff + {{(COUNT_BITS-1){1'b0}}, word_inc};
      fence_next  = content ? next_fence(fence_ph_ff, chr) : fence_ph_ff;
      marker_next = content ? next_marker(marker_ph_ff, chr) : marker_ph_ff;
   end

   // line end
   always_comb begin
      dashes    = marker_next == MarkDashes;
      dots      = marker_next == MarkDots;
      close_hit = !first_line_ff && seeking_ff && (dashes || dots);
      fence_hit = fence_next == FenceHit;
      add_line  = !close_hit && !fence_hit && !in_fence_ff;

      char_sum = {1'b0, total_chars_ff} + {1'b0, line_chars_ff} +
                 {{COUNT_BITS{1'b0}}, char_inc};
      word_sum = {1'b0, total_words_ff} + {1'b0, line_words_ff} +
                 {{COUNT_BITS{1'b0}}, word_inc};

      if (close_hit) begin
         ended_chars = '0;
         ended_words = '0;
      end else if (add_line) begin
         ended_chars = char_sum[COUNT_BITS] ? CountMax : char_sum[COUNT_BITS-1:0];
         ended_words = word_sum[COUNT_BITS] ? CountMax : word_sum[COUNT_BITS-1:0];
      end else begin
         ended_chars = total_chars_ff;
         ended_words = total_words_ff;
      end

      ended_fence   = close_hit ? 1'b0 : (fence_hit ? !in_fence_ff : in_fence_ff);
      ended_seeking = close_hit ? 1'b0 : ((first_line_ff && dashes) ? 1'b1 : seeking_ff);
   end

   // handshake
   always_comb begin
      fin_valid      = beat_valid_ff && beat_ff.end_of_text;
      fin_characters = ended_chars;
      fin_words      = ended_words;
      step           = beat_valid_ff && (!beat_ff.end_of_text || fin_ready);
      req_stall      = beat_valid_ff && !step;
      beat_valid_in  = req_stall ? 1'b1 : req_valid;
      beat_in        = req_stall ? beat_ff : req_data;
   end

   // next state
   always_comb begin
      total_chars_in = total_chars_ff;
      total_words_in = total_words_ff;
      line_chars_in  = line_chars_ff;
      line_words_in  = line_words_ff;
      in_word_in     = in_word_ff;
      in_fence_in    = in_fence_ff;
      prev_cr_in     = prev_cr_ff;
      first_line_in  = first_line_ff;
      seeking_in     = seeking_ff;
      fence_ph_in    = fence_ph_ff;
      marker_ph_in   = marker_ph_ff;
      if (step) begin
         if (beat_ff.end_of_text) begin
            total_chars_in = '0;
            total_words_in = '0;
            line_chars_in  = '0;
            line_words_in  = '0;
            in_word_in     = 1'b0;
            in_fence_in    = 1'b0;
            prev_cr_in     = 1'b0;
            first_line_in  = 1'b1;
            seeking_in     = 1'b0;
            fence_ph_in    = FenceLead;
            marker_ph_in   = MarkStart;
         end else if (line_break) begin
            total_chars_in = ended_chars;
            total_words_in = ended_words;
            line_chars_in  = '0;
            line_words_in  = '0;
            in_word_in     = 1'b0;
            in_fence_in    = ended_fence;
            prev_cr_in     = chr == ChrCr;
            first_line_in  = 1'b0;
            seeking_in     = ended_seeking;
            fence_ph_in    = FenceLead;
            marker_ph_in   = MarkStart;
         end else if (beat_ff.byte_valid) begin
            line_chars_in = line_chars_next;
            line_words_in = line_words_next;
            in_word_in    = content ? word_byte : in_word_ff;
            prev_cr_in    = 1'b0;
            fence_ph_in   = fence_next;
            marker_ph_in  = marker_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_valid_ff  <= 1'b0;
         total_chars_ff <= '0;
         total_words_ff <= '0;
         line_chars_ff  <= '0;
         line_words_ff  <= '0;
         in_word_ff     <= 1'b0;
         in_fence_ff    <= 1'b0;
         prev_cr_ff     <= 1'b0;
         first_line_ff  <= 1'b1;
         seeking_ff     <= 1'b0;
         fence_ph_ff    <= FenceLead;
         marker_ph_ff   <= MarkStart;
      end else begin
         beat_valid_ff  <= beat_valid_in;
         total_chars_ff <= total_chars_in;
         total_words_ff <= total_words_in;
         line_chars_ff  <= line_chars_in;
         line_words_ff  <= line_words_in;
         in_word_ff     <= in_word_in;
         in_fence_ff    <= in_fence_in;
         prev_cr_ff     <= prev_cr_in;
         first_line_ff  <= first_line_in;
         seeking_ff     <= seeking_in;
         fence_ph_ff    <= fence_ph_in;
         marker_ph_ff   <= marker_ph_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

endmodule

FILE: src/mts_result.sv
// ----------------------------------------------------------------------------
// mts_result: result pipeline for markdown text statistics
// Clamps the final totals to the result fields and computes the reading time
// as a reciprocal multiply, ending in the response register.
// ----------------------------------------------------------------------------
module mts_result #(
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fin_valid,
   output logic                  fin_ready,
   input  logic [COUNT_BITS-1:0] fin_characters,
   input  logic [COUNT_BITS-1:0] fin_words,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mts_pkg::rsp_type      rsp_data
);
   import mts_pkg::*;

   localparam int ExtBits  = (COUNT_BITS > 34) ? COUNT_BITS : 34;
   localparam int ProdBits = ScaledBits + RecipBits;

   logic                  a_valid_ff, a_valid_in;
   logic [COUNT_BITS-1:0] a_chars_ff, a_chars_in;
   logic [COUNT_BITS-1:0] a_words_ff, a_words_in;
   logic                  b_valid_ff, b_valid_in;
   logic [31:0]           b_chars_ff, b_chars_in;
   logic [31:0]           b_words_ff, b_words_in;
   logic                  b_over_ff, b_over_in;
   logic [ScaledBits-1:0] b_scaled_ff, b_scaled_in;
   logic                  c_valid_ff, c_valid_in;
   logic [31:0]           c_chars_ff, c_chars_in;
   logic [31:0]           c_words_ff, c_words_in;
   logic                  c_over_ff, c_over_in;
   logic [ProdBits-1:0]   c_prod_ff, c_prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  a_go, b_go, c_go, rsp_go;
   logic [ExtBits-1:0]    chars_ext;
   logic [ExtBits-1:0]    words_ext;
   logic [33:0]           biased;

   always_comb begin
      rsp_go    = !rsp_valid_ff || !rsp_stall;
      c_go      = !c_valid_ff || rsp_go;
      b_go      = !b_valid_ff || c_go;
      a_go      = !a_valid_ff || b_go;
      fin_ready = a_go;
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   // clamp and scale
   always_comb begin
      chars_ext  = ExtBits'(a_chars_ff);
      words_ext  = ExtBits'(a_words_ff);
      biased     = {1'b0, words_ext[32:0]} + WordsRoundUp;
      a_valid_in = a_go ? fin_valid : a_valid_ff;
      a_chars_in = a_go ? fin_characters : a_chars_ff;
      a_words_in = a_go ? fin_words : a_words_ff;

      b_valid_in  = b_go ? a_valid_ff : b_valid_ff;
      b_chars_in  = b_chars_ff;
      b_words_in  = b_words_ff;
      b_over_in   = b_over_ff;
      b_scaled_in = b_scaled_ff;
      if (b_go) begin
         b_chars_in  = (|chars_ext[ExtBits-1:32]) ? 32'hFFFF_FFFF : chars_ext[31:0];
         b_words_in  = (|words_ext[ExtBits-1:32]) ? 32'hFFFF_FFFF : words_ext[31:0];
         b_over_in   = words_ext > ExtBits'(MinutesWordLimit);
         b_scaled_in = biased[ScaledBits+2:3];
      end
   end

   // reciprocal multiply
   always_comb begin
      c_valid_in = c_go ? b_valid_ff : c_valid_ff;
      c_chars_in = c_go ? b_chars_ff : c_chars_ff;
      c_words_in = c_go ? b_words_ff : c_words_ff;
      c_over_in  = c_go ? b_over_ff : c_over_ff;
      c_prod_in  = c_go ? ProdBits'(b_scaled_ff) * ProdBits'(RecipMul) : c_prod_ff;
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_go ? c_valid_ff : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_go) begin
         rsp_data_in.character_count = c_chars_ff;
         rsp_data_in.word_count      = c_words_ff;
         rsp_data_in.reading_minutes = c_over_ff ? MinutesMax :
                                       c_prod_ff[RecipShift +: MinutesBits];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_chars_ff  <= a_chars_in;
      a_words_ff  <= a_words_in;
      b_chars_ff  <= b_chars_in;
      b_words_ff  <= b_words_in;
      b_over_ff   <= b_over_in;
      b_scaled_ff <= b_scaled_in;
      c_chars_ff  <= c_chars_in;
      c_words_ff  <= c_words_in;
      c_over_ff   <= c_over_in;
      c_prod_ff   <= c_prod_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
